// ----- rtl/core/tsam_pkg.sv -----
// types and constants shared by the two sorted array median unit
`default_nettype none

package tsam_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH_DEFAULT = 1024;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
    logic                     last;
  } pair_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] median_value;
    logic                     truncated;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/two_sorted_array_median_unit.sv -----
// lower median of two equal-length ascending sequences, loaded pair by pair into two memories
//
// Pairs are taken one per cycle while loading and written into two DEPTH-entry memories, A
// and B. The item marked last is stored like any other, then a halving search runs over the
// stored pairs and gives the lower median, the n-th smallest of the 2n values. Each search
// round is a memory read followed by a compare, as each memory has a single registered read
// port; no pair is taken during the search. A finished result waits in an output register
// and the next sequence may start loading meanwhile. Pairs beyond DEPTH are dropped and the
// result then carries truncated = 1. Memories need no clearing: only entries written in the
// current sequence are read.
`default_nettype none

module two_sorted_array_median_unit #(
  parameter int DEPTH = tsam_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pair_valid,
  output logic                  pair_ready,
  input  wire tsam_pkg::pair_t  pair,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output tsam_pkg::result_t     res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RD   = 3'b010,
    ST_CMP  = 3'b100
  } state_t;

  state_t state;

  logic [tsam_pkg::DATA_W-1:0] mem_a [DEPTH];
  logic [tsam_pkg::DATA_W-1:0] mem_b [DEPTH];
  logic [tsam_pkg::DATA_W-1:0] rd_a;
  logic [tsam_pkg::DATA_W-1:0] rd_b;

  logic [CNTW-1:0] pair_count;
  logic            overflow_seen;
  logic            trunc;
  logic            fin;
  logic [AW-1:0]   lo_a, hi_a, lo_b, hi_b;

  logic            accept;
  logic            room;
  logic [CNTW-1:0] n_pairs;
  logic [AW:0]     sum_a, sum_b;
  logic [AW-1:0]   mid_a, mid_b;
  logic            lt;
  logic            done;
  logic            deliver;

  assign pair_ready = (state == ST_LOAD);
  assign accept     = pair_valid && pair_ready;
  assign room       = (pair_count < DEPTH_C);
  assign n_pairs    = room ? CNTW'(pair_count + CNTW'(1)) : pair_count;

  assign sum_a = {1'b0, lo_a} + {1'b0, hi_a};
  assign sum_b = {1'b0, lo_b} + {1'b0, hi_b};
  assign mid_a = sum_a[AW:1];
  assign mid_b = sum_b[AW:1];

  assign lt      = $signed(rd_a) < $signed(rd_b);
  assign done    = fin || (rd_a == rd_b);
  assign deliver = done && (!res_valid || res_ready);

  // memory ports
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem_a[pair_count[AW-1:0]] <= pair.a_value;
      mem_b[pair_count[AW-1:0]] <= pair.b_value;
    end
    rd_a <= mem_a[mid_a];
    rd_b <= mem_b[mid_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && res_ready && !((state == ST_CMP) && deliver)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (pair.last) begin
              lo_a          <= '0;
              lo_b          <= '0;
              hi_a          <= AW'(n_pairs - CNTW'(1));
              hi_b          <= AW'(n_pairs - CNTW'(1));
              trunc         <= overflow_seen || !room;
              pair_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_RD;
            end else if (room) begin
              pair_count <= CNTW'(pair_count + CNTW'(1));
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        ST_RD: begin
          fin   <= (lo_a == hi_a) && (lo_b == hi_b);
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (done) begin
            if (deliver) begin
              res_valid        <= 1'b1;
              res.median_value <= lt ? rd_a : rd_b;
              res.truncated    <= trunc;
              state            <= ST_LOAD;
            end
          end else begin
            if (lt) begin
              lo_a <= sum_a[0] ? AW'(mid_a + AW'(1)) : mid_a;
              hi_b <= mid_b;
            end else begin
              hi_a <= mid_a;
              lo_b <= sum_b[0] ? AW'(mid_b + AW'(1)) : mid_b;
            end
            state <= ST_RD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= DEPTH_C)
    else $error("pair count beyond depth");

  a_ranges_ordered: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> ((lo_a <= hi_a) && (lo_b <= hi_b)))
    else $error("search range inverted");

  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_CMP))
    else $error("result raised outside search");

  a_no_load_during_search: assert property (@(posedge clk) disable iff (rst)
    (accept && pair.last) |=> (state == ST_RD) && (pair_count == '0))
    else $error("search did not start after last item");

endmodule

`default_nettype wire
